### rtl/core/gn_pkg.sv
// package: constants, types and helper functions for the gradient noise block
`timescale 1ns / 1ps
package gn_pkg;
	localparam int FracBits = 16;
	localparam int TableSize = 256;
	localparam int AddrW = 8;
	localparam int CoordW = 24;
	localparam int OutW = 19;
	localparam int CornerW = 20;
	localparam int FadeW = 17;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_N2D  = 2'd1,
		KIND_N3D  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef logic signed [2:0] grad_t;
	typedef logic signed [CornerW-1:0] corner_t;

	// gradient lookup, hash masked to 5 bits
	function automatic logic [5:0] grad_code(input logic [4:0] h);
		logic [5:0] g;
		begin
			case (h)
				5'd0, 5'd12:  g = 6'b00_01_01;
				5'd1, 5'd13:  g = 6'b00_01_11;
				5'd2, 5'd14:  g = 6'b00_11_01;
				5'd3, 5'd15:  g = 6'b00_11_11;
				5'd4, 5'd16:  g = 6'b01_00_01;
				5'd5, 5'd17:  g = 6'b01_00_11;
				5'd6, 5'd18:  g = 6'b11_00_01;
				5'd7, 5'd19:  g = 6'b11_00_11;
				5'd8, 5'd20:  g = 6'b01_01_00;
				5'd9, 5'd21:  g = 6'b01_11_00;
				5'd10, 5'd22: g = 6'b11_01_00;
				5'd11, 5'd23: g = 6'b11_11_00;
				5'd24: g = 6'b01_01_01;
				5'd25: g = 6'b01_01_11;
				5'd26: g = 6'b01_11_01;
				5'd27: g = 6'b11_01_01;
				5'd28: g = 6'b01_11_11;
				5'd29: g = 6'b11_01_11;
				5'd30: g = 6'b11_11_01;
				default: g = 6'b11_11_11;
			endcase
			return g;
		end
	endfunction

	// add or subtract one offset by a 2-bit sign code
	function automatic corner_t gterm(input logic [1:0] c, input corner_t d);
		corner_t r;
		begin
			case (c)
				2'b01:   r = d;
				2'b11:   r = -d;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// round half away from zero after a right shift by FracBits
	function automatic logic signed [63:0] rshift(input logic signed [63:0] v);
		logic [63:0] m;
		logic [63:0] half;
		begin
			half = 64'd1 << (FracBits - 1);
			m = v[63] ? 64'(-v) : 64'(v);
			m = (m + half) >> FracBits;
			return v[63] ? -$signed(m) : $signed(m);
		end
	endfunction
endpackage

### rtl/core/gn_hash.sv
// lattice hash: chained permutation lookups giving eight gradient hashes
`timescale 1ns / 1ps
module gn_hash import gn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [7:0] wr_data,
	input  logic in_valid,
	input  logic three,
	input  logic [AddrW-1:0] ix,
	input  logic [AddrW-1:0] iy,
	input  logic [AddrW-1:0] iz,
	output logic out_valid,
	output logic [39:0] hashes
);
	// one table copy per read port: two on the z level, four on y, eight on x
	logic [7:0] mem_z [2][TableSize];
	logic [7:0] mem_y [4][TableSize];
	logic [7:0] mem_x [8][TableSize];

	logic v_s1, v_s2, v_s3;
	logic [AddrW-1:0] ix_s1, iy_s1, ix_s2;
	logic [7:0] z_s1 [2];
	logic [7:0] a_s2 [4];
	logic [39:0] h_s3;
	logic wr_s1, wr_s2;
	logic [AddrW-1:0] wa_s1, wa_s2;
	logic [7:0] wd_s1, wd_s2;

	// a load word writes each level as it passes it, keeping lookups in order
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 2; i++) mem_z[i][wr_addr] <= wr_data;
		end
		if (en && wr_s1) begin
			for (int i = 0; i < 4; i++) mem_y[i][wa_s1] <= wd_s1;
		end
		if (en && wr_s2) begin
			for (int i = 0; i < 8; i++) mem_x[i][wa_s2] <= wd_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			wr_s1 <= 1'b0;
			wr_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			wr_s1 <= wr_en;
			wr_s2 <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s1 <= wr_addr;
			wd_s1 <= wr_data;
			wa_s2 <= wa_s1;
			wd_s2 <= wd_s1;
			ix_s1 <= ix;
			iy_s1 <= iy;
			// 2d mode uses the y level as the first lookup
			z_s1[0] <= three ? mem_z[0][iz] : 8'd0;
			z_s1[1] <= three ? mem_z[1][AddrW'(iz + 1'b1)] : 8'd0;
			ix_s2 <= ix_s1;
			for (int i = 0; i < 4; i++)
				a_s2[i] <= mem_y[i][AddrW'(iy_s1 + AddrW'(i[0]) + z_s1[i>>1])];
			for (int i = 0; i < 8; i++)
				h_s3[i*5 +: 5] <= mem_x[i][AddrW'(ix_s2 + AddrW'(i[0])
					+ a_s2[i>>1])][4:0];
		end
	end

	// in 2d the z level gives zero, so corners 0..3 take perm(iy) and perm(iy+1)
	logic [39:0] h_fix;
	always_comb begin
		h_fix = h_s3;
	end

	assign out_valid = v_s3;
	assign hashes = h_fix;
endmodule

### rtl/core/gn_blend.sv
// corner dot products, fade curves and trilinear blend (bilinear in 2d mode)
`timescale 1ns / 1ps
module gn_blend import gn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic three,
	input  logic [FracBits-1:0] fx,
	input  logic [FracBits-1:0] fy,
	input  logic [FracBits-1:0] fz,
	input  logic [39:0] hashes,
	output logic out_valid,
	output logic signed [OutW-1:0] result
);
	localparam logic signed [63:0] One = 64'sd1 <<< FracBits;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [FadeW-1:0] t2_s1 [3];
	logic [FracBits-1:0] f_s1 [3];
	logic [FadeW-1:0] t3_s2 [3];
	logic signed [23:0] q_s2 [3];
	logic [FadeW-1:0] w_s3 [3];
	corner_t n_s3 [8];
	logic signed [23:0] l1_s4 [4];
	logic signed [23:0] l2_s5 [2];
	logic signed [23:0] l3_s6;
	logic [FadeW-1:0] w_s4 [3], w_s5 [3];
	logic three_s [5];
	logic [39:0] h_s1, h_s2;
	logic signed [OutW-1:0] res_s7;

	function automatic logic [FadeW-1:0] clampw(input logic signed [63:0] r);
		begin
			if (r > One) return FadeW'(One);
			if (r < 0) return '0;
			return FadeW'(r);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1[0] <= fx; f_s1[1] <= fy; f_s1[2] <= fz;
			t2_s1[0] <= FadeW'(rshift(64'(fx) * 64'(fx)));
			t2_s1[1] <= FadeW'(rshift(64'(fy) * 64'(fy)));
			t2_s1[2] <= FadeW'(rshift(64'(fz) * 64'(fz)));
			h_s1 <= hashes;
			three_s[0] <= three;
			for (int i = 0; i < 3; i++) begin
				t3_s2[i] <= FadeW'(rshift(64'(t2_s1[i]) * 64'(f_s1[i])));
				q_s2[i] <= 24'(6 * 64'(t2_s1[i]) - 15 * 64'(f_s1[i]) + 10 * One);
			end
			h_s2 <= h_s1;
			three_s[1] <= three_s[0];
			for (int i = 0; i < 3; i++)
				w_s3[i] <= clampw(rshift(64'(t3_s2[i]) * 64'(q_s2[i])));
			three_s[2] <= three_s[1];
			w_s4 <= w_s3;
			w_s5 <= w_s4;
			for (int i = 3; i < 5; i++) three_s[i] <= three_s[i-1];
			for (int i = 0; i < 4; i++)
				l1_s4[i] <= 24'(64'(n_s3[2*i]) + rshift((64'(n_s3[2*i+1])
					- 64'(n_s3[2*i])) * 64'(w_s3[0])));
			for (int i = 0; i < 2; i++)
				l2_s5[i] <= 24'(64'(l1_s4[2*i]) + rshift((64'(l1_s4[2*i+1])
					- 64'(l1_s4[2*i])) * 64'(w_s4[1])));
			l3_s6 <= three_s[4] ? 24'(64'(l2_s5[0]) + rshift((64'(l2_s5[1])
				- 64'(l2_s5[0])) * 64'(w_s5[2]))) : l2_s5[0];
			if (l3_s6 > 24'sd262143) res_s7 <= 19'sd262143;
			else if (l3_s6 < -24'sd262144) res_s7 <= -19'sd262144;
			else res_s7 <= OutW'(l3_s6);
		end
	end

	// dot products, fractions delayed to line up with the hashes
	logic [FracBits-1:0] fd_s2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			fd_s2 <= f_s1;
			for (int c = 0; c < 8; c++) begin
				logic [5:0] g;
				corner_t dx, dy, dz;
				g = grad_code(h_s2[c*5 +: 5]);
				dx = c[0] ? corner_t'(fd_s2[0]) - corner_t'(One) : corner_t'(fd_s2[0]);
				dy = c[1] ? corner_t'(fd_s2[1]) - corner_t'(One) : corner_t'(fd_s2[1]);
				dz = c[2] ? corner_t'(fd_s2[2]) - corner_t'(One) : corner_t'(fd_s2[2]);
				n_s3[c] <= gterm(g[5:4], dx) + gterm(g[3:2], dy)
					+ (three_s[1] ? gterm(g[1:0], dz) : corner_t'(0));
			end
		end
	end

	assign out_valid = v_s7;
	assign result = res_s7;
endmodule

### rtl/core/gradient_noise_2d_3d_top.sv
// top level: gradient noise pipeline with output register
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | kind, perm_index, perm_value, coord_x/y/z
// out     | out | out_valid/out_ready| noise_value
// one word accepted per cycle while out is not stalled
// rate: one word per cycle unless out stalls, set by the per-level table copies in the hash unit
// reset clears all valid bits; table contents are undefined until loaded
// a stall on out holds the whole pipeline; a load word writes each table level
// as it passes it, so words ahead of it still see the old entry
`timescale 1ns / 1ps
module gradient_noise_2d_3d_top import gn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] perm_index,
	input  logic [7:0] perm_value,
	input  logic signed [CoordW-1:0] coord_x,
	input  logic signed [CoordW-1:0] coord_y,
	input  logic signed [CoordW-1:0] coord_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OutW-1:0] noise_value
);
	logic en, acc, noise_in, h_valid, b_valid, three;
	logic [39:0] hashes;
	logic [39:0] hsel;
	logic signed [OutW-1:0] b_res;
	logic [FracBits-1:0] fx_d [3], fy_d [3], fz_d [3];
	logic three_d [3];

	// pipeline advances when the output register is free or being drained
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign acc = in_valid && in_ready;
	assign noise_in = acc && (kind == KIND_N2D || kind == KIND_N3D);
	assign three = (kind == KIND_N3D);

	gn_hash u_hash (
		.clk, .arst_n, .en,
		.wr_en(acc && kind == KIND_LOAD),
		.wr_addr(perm_index), .wr_data(perm_value),
		.in_valid(noise_in), .three,
		.ix(coord_x[FracBits +: AddrW]),
		.iy(coord_y[FracBits +: AddrW]),
		.iz(coord_z[FracBits +: AddrW]),
		.out_valid(h_valid), .hashes
	);

	// fractions travel alongside the hash stages
	always_ff @(posedge clk) begin
		if (en) begin
			fx_d[0] <= coord_x[FracBits-1:0];
			fy_d[0] <= coord_y[FracBits-1:0];
			fz_d[0] <= coord_z[FracBits-1:0];
			three_d[0] <= three;
			for (int i = 1; i < 3; i++) begin
				fx_d[i] <= fx_d[i-1];
				fy_d[i] <= fy_d[i-1];
				fz_d[i] <= fz_d[i-1];
				three_d[i] <= three_d[i-1];
			end
		end
	end

	// corner order is x fastest, then y, then z; 2d uses corners 0..3 only
	assign hsel = hashes;

	gn_blend u_blend (
		.clk, .arst_n, .en,
		.in_valid(h_valid), .three(three_d[2]),
		.fx(fx_d[2]), .fy(fy_d[2]), .fz(fz_d[2]),
		.hashes(hsel),
		.out_valid(b_valid), .result(b_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) noise_value <= b_res;
	end
endmodule

### rtl/core/gn_checker.sv
// port checker for the gradient noise top level
`timescale 1ns / 1ps
module gn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [18:0] noise_value
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("output word dropped while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during stall");
endmodule

bind gradient_noise_2d_3d_top gn_checker u_chk (.*);
